// ===== rtl/lhe_pkg.sv =====
// ----------------------------------------------------------------------------
// lhe_pkg: shared types and constants of the label histogram
// Field widths, mode codes and the command and status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lhe_pkg;

	localparam int BINS       = 64;
	localparam int IDX_W      = 6;
	localparam int CNT_W      = 24;
	localparam int FRAC_W     = 16;
	localparam int K_W        = 5;
	localparam int LOG_W      = K_W + FRAC_W;
	localparam int PROD_W     = CNT_W + LOG_W;
	localparam int SUM_W      = 52;
	localparam int ENT_W      = 19;
	localparam int ACT_W      = 7;
	localparam int MODE_W     = 3;
	localparam int MANT_W     = 31;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [ENT_W-1:0] ENT_MAX = {ENT_W{1'b1}};
	localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(64);
	localparam logic [ACT_W-1:0] ACT_LIMIT = ACT_W'(BINS);

	localparam logic [MODE_W-1:0] MODE_COUNT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MERGE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SET   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ENT   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_READ  = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic ent_rd;
		logic ent_init;
		logic log_bin;
		logic log_tot;
		logic mul;
		logic acc;
		logic bin_next;
		logic div_step;
		logic ent_fin;
		logic commit;
	} lhe_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_ent;
		logic total_zero;
		logic nb_zero;
		logic cnt_zero;
		logic bin_last;
		logic lg_busy;
		logic div_last;
		logic out_free;
	} lhe_stat_t;

endpackage

// ===== rtl/lhe_log2.sv =====
// ----------------------------------------------------------------------------
// lhe_log2: iterative fixed-point base-2 logarithm
// Leading-one position gives the integer part; one squaring of the mantissa
// per cycle gives each fraction bit.
// ----------------------------------------------------------------------------
module lhe_log2 (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lhe_pkg::CNT_W-1:0]   x,
	output logic                        busy,
	output logic [lhe_pkg::LOG_W-1:0]   result
);

	localparam int STEP_W = $clog2(lhe_pkg::FRAC_W);

	logic [lhe_pkg::K_W-1:0]    lead;
	logic [lhe_pkg::K_W-1:0]    k_q;
	logic [lhe_pkg::MANT_W-1:0] m_q;
	logic [lhe_pkg::FRAC_W-1:0] frac_q;
	logic [STEP_W-1:0]          step_q;
	logic                       busy_q;
	logic [2*lhe_pkg::MANT_W-1:0] sq;
	logic [lhe_pkg::MANT_W:0]     sq_t;

	// Position of the leading one of the input.
	always_comb begin
		lead = '0;
		for (int i = 0; i < lhe_pkg::CNT_W; i++) begin
			if (x[i]) begin
				lead = lhe_pkg::K_W'(i);
			end
		end
	end

	// Square of the mantissa, truncated to Q2.30; the update brings it back to Q1.30.
	assign sq   = m_q * m_q;
	assign sq_t = sq[2*lhe_pkg::MANT_W-1:lhe_pkg::MANT_W-1];

	// One fraction bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(lhe_pkg::FRAC_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			k_q    <= lead;
			m_q    <= lhe_pkg::MANT_W'(x) << (lhe_pkg::K_W'(30) - lead);
			frac_q <= '0;
		end else if (busy_q) begin
			if (sq_t[lhe_pkg::MANT_W]) begin
				m_q    <= sq_t[lhe_pkg::MANT_W:1];
				frac_q <= {frac_q[lhe_pkg::FRAC_W-2:0], 1'b1};
			end else begin
				m_q    <= sq_t[lhe_pkg::MANT_W-1:0];
				frac_q <= {frac_q[lhe_pkg::FRAC_W-2:0], 1'b0};
			end
		end
	end

	assign busy   = busy_q;
	assign result = {k_q, frac_q};

endmodule

// ===== rtl/lhe_datapath.sv =====
// ----------------------------------------------------------------------------
// lhe_datapath: bin memory, total, entropy arithmetic and result register
// Executes the commands of the controller and reports status back.
// ----------------------------------------------------------------------------
module lhe_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lhe_pkg::lhe_cmd_t             cmd,
	output lhe_pkg::lhe_stat_t            stat,
	input  logic                          cfg_we,
	input  logic [lhe_pkg::ACT_W-1:0]     cfg_data,
	input  logic [lhe_pkg::MODE_W-1:0]    mode,
	input  logic [lhe_pkg::IDX_W-1:0]     bin_index,
	input  logic [lhe_pkg::CNT_W-1:0]     amount,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [lhe_pkg::CNT_W-1:0]     bin_value,
	output logic [lhe_pkg::CNT_W-1:0]     total_samples,
	output logic [lhe_pkg::ENT_W-1:0]     entropy_bits,
	output logic                          bad_bin,
	output logic                          saturated
);

	logic [lhe_pkg::CNT_W-1:0]  mem [lhe_pkg::BINS];
	logic [lhe_pkg::BINS-1:0]   vld_q;
	logic [lhe_pkg::CNT_W-1:0]  rd_data_q;
	logic                       rd_vld_q;
	logic [lhe_pkg::IDX_W-1:0]  rd_addr;
	logic [lhe_pkg::ACT_W-1:0]  active_q;
	logic [lhe_pkg::ACT_W-1:0]  eff;
	logic [lhe_pkg::CNT_W-1:0]  total_q;
	logic [lhe_pkg::MODE_W-1:0] mode_q;
	logic [lhe_pkg::IDX_W-1:0]  idx_q;
	logic [lhe_pkg::CNT_W-1:0]  amt_q;
	logic [lhe_pkg::IDX_W-1:0]  bin_q;
	logic [lhe_pkg::CNT_W-1:0]  c_q;
	logic [lhe_pkg::PROD_W-1:0] prod_q;
	logic [lhe_pkg::SUM_W-1:0]  sum_q;
	logic [lhe_pkg::CNT_W-1:0]  rem_q;
	logic [5:0]                 div_q;
	logic [lhe_pkg::ENT_W-1:0]  ent_q;
	logic                       ent_clip_q;
	logic                       out_valid_q;
	logic [lhe_pkg::CNT_W-1:0]  old;
	logic                       lg_start;
	logic [lhe_pkg::CNT_W-1:0]  lg_x;
	logic                       lg_busy;
	logic [lhe_pkg::LOG_W-1:0]  lg_res;
	logic [lhe_pkg::CNT_W:0]    rr;
	logic                       qbit;

	// Results of the item being committed.
	logic                       bad;
	logic                       clip;
	logic                       wr_en;
	logic                       clr_all;
	logic [lhe_pkg::CNT_W-1:0]  new_bin;
	logic [lhe_pkg::CNT_W-1:0]  new_total;
	logic [lhe_pkg::CNT_W-1:0]  binv;
	logic [lhe_pkg::ENT_W-1:0]  entv;
	logic [lhe_pkg::CNT_W:0]    s_bin;
	logic [lhe_pkg::CNT_W:0]    s_tot;
	logic [lhe_pkg::CNT_W-1:0]  add;
	logic [lhe_pkg::CNT_W-1:0]  diff;

	// Effective number of bins.
	assign eff = (active_q > lhe_pkg::ACT_LIMIT) ? lhe_pkg::ACT_LIMIT : active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= lhe_pkg::ACT_RESET;
		end else if (cfg_we) begin
			active_q <= cfg_data;
		end
	end

	// Bin memory with one valid bit per entry so that a clear empties every entry at once.
	assign rd_addr = cmd.take ? bin_index : bin_q;

	always_ff @(posedge clk) begin
		if (cmd.take || cmd.ent_rd) begin
			rd_data_q <= mem[rd_addr];
			rd_vld_q  <= vld_q[rd_addr];
		end
		if (wr_en) begin
			mem[idx_q] <= new_bin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr_all) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[idx_q] <= 1'b1;
		end
	end

	assign old = rd_vld_q ? rd_data_q : '0;

	// Latched item.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q <= mode;
			idx_q  <= bin_index;
			amt_q  <= amount;
		end
	end

	// Per-mode update of bin and total.
	always_comb begin
		bad       = 1'b0;
		clip      = 1'b0;
		wr_en     = 1'b0;
		clr_all   = 1'b0;
		new_bin   = old;
		new_total = total_q;
		binv      = '0;
		entv      = '0;
		add       = '0;
		diff      = '0;
		s_bin     = '0;
		s_tot     = '0;
		case (mode_q) inside
			lhe_pkg::MODE_COUNT, lhe_pkg::MODE_MERGE, lhe_pkg::MODE_SET,
			lhe_pkg::MODE_READ: begin
				if ({1'b0, idx_q} >= eff) begin
					bad = 1'b1;
				end else if (mode_q == lhe_pkg::MODE_SET) begin
					wr_en   = 1'b1;
					new_bin = amt_q;
					binv    = amt_q;
					if (amt_q >= old) begin
						s_tot = {1'b0, total_q} + {1'b0, amt_q - old};
						if (s_tot > {1'b0, lhe_pkg::CNT_MAX}) begin
							clip      = 1'b1;
							new_total = lhe_pkg::CNT_MAX;
						end else begin
							new_total = s_tot[lhe_pkg::CNT_W-1:0];
						end
					end else begin
						diff = old - amt_q;
						if (diff > total_q) begin
							clip      = 1'b1;
							new_total = '0;
						end else begin
							new_total = total_q - diff;
						end
					end
				end else if (mode_q == lhe_pkg::MODE_READ) begin
					binv = old;
				end else begin
					wr_en = 1'b1;
					add   = (mode_q == lhe_pkg::MODE_COUNT) ?
						lhe_pkg::CNT_W'(1) : amt_q;
					s_bin = {1'b0, old} + {1'b0, add};
					s_tot = {1'b0, total_q} + {1'b0, add};
					if (s_bin > {1'b0, lhe_pkg::CNT_MAX}) begin
						clip    = 1'b1;
						new_bin = lhe_pkg::CNT_MAX;
					end else begin
						new_bin = s_bin[lhe_pkg::CNT_W-1:0];
					end
					if (s_tot > {1'b0, lhe_pkg::CNT_MAX}) begin
						clip      = 1'b1;
						new_total = lhe_pkg::CNT_MAX;
					end else begin
						new_total = s_tot[lhe_pkg::CNT_W-1:0];
					end
					binv = new_bin;
				end
			end
			lhe_pkg::MODE_CLEAR: begin
				clr_all   = 1'b1;
				new_total = '0;
			end
			lhe_pkg::MODE_ENT: begin
				entv = ent_q;
				clip = ent_clip_q;
			end
			default: begin
			end
		endcase
		wr_en   = wr_en & cmd.commit;
		clr_all = clr_all & cmd.commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.commit) begin
			total_q <= new_total;
		end
	end

	// Shared logarithm unit.
	assign lg_start = cmd.log_bin | cmd.log_tot;
	assign lg_x     = cmd.log_tot ? total_q : old;

	lhe_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lg_start),
		.x      (lg_x),
		.busy   (lg_busy),
		.result (lg_res)
	);

	// Restoring division of the product sum by the total, one bit a cycle.
	assign rr   = {rem_q, sum_q[lhe_pkg::SUM_W-1]};
	assign qbit = (rr >= {1'b0, total_q});

	// Entropy walk: bin counter, product, sum, quotient and final result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
			div_q <= '0;
		end else begin
			if (cmd.ent_init) begin
				bin_q <= '0;
				div_q <= '0;
			end else begin
				if (cmd.bin_next) begin
					bin_q <= bin_q + 1'b1;
				end
				if (cmd.div_step) begin
					div_q <= div_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.log_bin) begin
			c_q <= old;
		end
		if (cmd.mul) begin
			prod_q <= c_q * lg_res;
		end
		if (cmd.ent_init) begin
			sum_q      <= '0;
			rem_q      <= '0;
			ent_q      <= '0;
			ent_clip_q <= 1'b0;
		end else begin
			if (cmd.acc) begin
				sum_q <= sum_q + lhe_pkg::SUM_W'(prod_q);
			end
			if (cmd.div_step) begin
				if (qbit) begin
					rem_q <= lhe_pkg::CNT_W'(rr - {1'b0, total_q});
				end else begin
					rem_q <= rr[lhe_pkg::CNT_W-1:0];
				end
				sum_q <= {sum_q[lhe_pkg::SUM_W-2:0], qbit};
			end
			if (cmd.ent_fin) begin
				if (sum_q >= lhe_pkg::SUM_W'(lg_res)) begin
					ent_q <= '0;
				end else if ((lg_res - lhe_pkg::LOG_W'(sum_q)) >
					lhe_pkg::LOG_W'(lhe_pkg::ENT_MAX)) begin
					ent_q      <= lhe_pkg::ENT_MAX;
					ent_clip_q <= 1'b1;
				end else begin
					ent_q <= lhe_pkg::ENT_W'(lg_res - lhe_pkg::LOG_W'(sum_q));
				end
			end
		end
	end

	// Result register; it frees the block while the word waits downstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			bin_value     <= binv;
			total_samples <= new_total;
			entropy_bits  <= entv;
			bad_bin       <= bad;
			saturated     <= clip;
		end
	end

	assign out_valid = out_valid_q;

	// Status to the controller.
	assign stat.in_ent     = (mode == lhe_pkg::MODE_ENT);
	assign stat.total_zero = (total_q == '0);
	assign stat.nb_zero    = (eff == '0);
	assign stat.cnt_zero   = (old == '0);
	assign stat.bin_last   = ({1'b0, bin_q} == (eff - 1'b1));
	assign stat.lg_busy    = lg_busy;
	assign stat.div_last   = (div_q == 6'(lhe_pkg::SUM_W - 1));
	assign stat.out_free   = !out_valid_q || out_ready;

endmodule

// ===== rtl/lhe_ctrl.sv =====
// ----------------------------------------------------------------------------
// lhe_ctrl: sequencer of the label histogram
// Accepts items, walks the bins for entropy and hands words to the output.
// ----------------------------------------------------------------------------
module lhe_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lhe_pkg::lhe_stat_t   stat,
	output lhe_pkg::lhe_cmd_t    cmd
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_FIN   = 11'b00000000010,
		S_START = 11'b00000000100,
		S_RD    = 11'b00000001000,
		S_LD    = 11'b00000010000,
		S_LOG   = 11'b00000100000,
		S_MUL   = 11'b00001000000,
		S_ACC   = 11'b00010000000,
		S_DIV   = 11'b00100000000,
		S_LOGN  = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = stat.in_ent ? S_START : S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_START: begin
				cmd.ent_init = 1'b1;
				if (stat.total_zero) begin
					state_d = S_FIN;
				end else if (stat.nb_zero) begin
					state_d = S_DIV;
				end else begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.ent_rd = 1'b1;
				state_d    = S_LD;
			end
			S_LD: begin
				if (stat.cnt_zero) begin
					cmd.bin_next = 1'b1;
					state_d      = stat.bin_last ? S_DIV : S_RD;
				end else begin
					cmd.log_bin = 1'b1;
					state_d     = S_LOG;
				end
			end
			S_LOG: begin
				if (!stat.lg_busy) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc      = 1'b1;
				cmd.bin_next = 1'b1;
				state_d      = stat.bin_last ? S_DIV : S_RD;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					cmd.log_tot = 1'b1;
					state_d     = S_LOGN;
				end
			end
			S_LOGN: begin
				if (!stat.lg_busy) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.ent_fin = 1'b1;
				state_d     = S_FIN;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/label_histogram_entropy.sv =====
// ----------------------------------------------------------------------------
// label_histogram_entropy: label histogram with Shannon entropy
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Count, merge, set, clear and read words each pass through two states:
// the idle state reads the addressed bin from the 64-entry bin memory, and
// the finish state updates it and loads the result register once the
// output is free. An entropy word walks the active bins one at a time
// through a shared logarithm unit that squares once per fraction bit; an
// empty bin skips the logarithm. A bit-serial division and a logarithm of
// the total then follow. A new word is taken while the previous result
// still waits in the output register. The configuration register is
// always ready and is to be written only while the block is idle.
module label_histogram_entropy (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lhe_pkg::ACT_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lhe_pkg::MODE_W-1:0]    mode,
	input  logic [lhe_pkg::IDX_W-1:0]     bin_index,
	input  logic [lhe_pkg::CNT_W-1:0]     amount,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lhe_pkg::CNT_W-1:0]     bin_value,
	output logic [lhe_pkg::CNT_W-1:0]     total_samples,
	output logic [lhe_pkg::ENT_W-1:0]     entropy_bits,
	output logic                          bad_bin,
	output logic                          saturated
);

	lhe_pkg::lhe_cmd_t  cmd;
	lhe_pkg::lhe_stat_t stat;

	assign cfg_ready = 1'b1;

	lhe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lhe_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_valid),
		.cfg_data      (cfg_data),
		.mode          (mode),
		.bin_index     (bin_index),
		.amount        (amount),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.bin_value     (bin_value),
		.total_samples (total_samples),
		.entropy_bits  (entropy_bits),
		.bad_bin       (bad_bin),
		.saturated     (saturated)
	);

endmodule
